FILE: rtl/pffla_pkg.sv
`default_nettype none
package pffla_pkg;

	// Page frames are numbered from this address upward.
	localparam logic [31:0] BASE_ADDR = 32'h8000_0000;

	typedef enum logic [1:0] {
		K_INIT  = 2'd0,
		K_FREE  = 2'd1,
		K_ALLOC = 2'd2,
		K_NOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_RSVD   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT_SET,
		S_INIT_RUN,
		S_FREE,
		S_ALLOC_RD,
		S_ALLOC_WB,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic capture;
		logic init_load;
		logic init_step;
		logic free_exec;
		logic alloc_rd;
		logic alloc_wb;
	} ctl_cmd_t;

	typedef struct packed {
		logic init_more;
		logic head_null;
	} ctl_sts_t;

endpackage
`default_nettype wire

FILE: rtl/pffla_ctrl.sv
`default_nettype none
module pffla_ctrl
	import pffla_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic [1:0] kind,
	input  wire ctl_sts_t sts,
	output ctl_cmd_t      cmd,
	output logic          busy,
	output logic          done
);

	state_t state_q, state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = !(state_q == S_IDLE || state_q == S_REPLY);
		done    = (state_q == S_REPLY);
		accept  = start && !busy;

		unique case (state_q)
			S_IDLE, S_REPLY: begin
				state_d = S_IDLE;
				if (accept) begin
					cmd.capture = 1'b1;
					unique case (kind_t'(kind))
						K_INIT:  state_d = S_INIT_SET;
						K_FREE:  state_d = S_FREE;
						K_ALLOC: state_d = S_ALLOC_RD;
						K_NOP:   state_d = S_REPLY;
					endcase
				end
			end
			S_INIT_SET: begin
				cmd.init_load = 1'b1;
				state_d       = S_INIT_RUN;
			end
			S_INIT_RUN: begin
				// one page pushed per cycle until the counter reaches the top
				if (sts.init_more) begin
					cmd.init_step = 1'b1;
				end else begin
					state_d = S_REPLY;
				end
			end
			S_FREE: begin
				cmd.free_exec = 1'b1;
				state_d       = S_REPLY;
			end
			S_ALLOC_RD: begin
				cmd.alloc_rd = 1'b1;
				state_d      = sts.head_null ? S_REPLY : S_ALLOC_WB;
			end
			S_ALLOC_WB: begin
				cmd.alloc_wb = 1'b1;
				state_d      = S_REPLY;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/pffla_dp.sv
`default_nettype none
module pffla_dp
	import pffla_pkg::*;
#(
	parameter int NUM_PAGES  = 131072,
	parameter int PAGE_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_cmd_t    cmd,
	output ctl_sts_t         sts,
	input  wire logic [31:0] address,
	input  wire logic        cfg_write,
	input  wire logic [31:0] cfg_data,
	output logic [31:0]      page_address,
	output logic [1:0]       status
);

	localparam int PG_SH = $clog2(PAGE_BYTES);
	localparam int AW    = $clog2(NUM_PAGES);
	localparam int IDX_W = AW + 1;

	localparam longint unsigned TOP_RAW =
		64'h8000_0000 + 64'(NUM_PAGES) * 64'(PAGE_BYTES);
	localparam longint unsigned TOP = (TOP_RAW > 64'h1_0000_0000) ? 64'h1_0000_0000 : TOP_RAW;
	// pages that lie between the base and the (capped) top
	localparam longint unsigned NPU = (TOP - 64'h8000_0000) / PAGE_BYTES;

	localparam logic [32:0]      TOP33    = 33'(TOP);
	localparam logic [31:0]      NPU32    = 32'(NPU);
	localparam logic [IDX_W-1:0] NPU_IDX  = IDX_W'(NPU);
	localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(NUM_PAGES);
	localparam logic [31:0]      PG_MASK  = 32'(PAGE_BYTES - 1);

	logic [IDX_W-1:0] link_mem [NUM_PAGES];

	logic [31:0]      region_start_q;
	logic [31:0]      addr_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] rd_q;
	logic [31:0]      page_q;
	status_t          status_q;

	logic             free_ok;
	logic [IDX_W-1:0] free_idx;
	logic [31:0]      init_first;
	logic [IDX_W-1:0] init_load_val;
	logic             push;
	logic [IDX_W-1:0] push_idx;

	always_comb begin
		free_ok = (addr_q[PG_SH-1:0] == '0) && (addr_q >= region_start_q) && addr_q[31]
			&& ({1'b0, addr_q} < TOP33);
		free_idx = IDX_W'(addr_q[30:PG_SH]);

		// first page index of init: region start rounded up, clamped to the base
		if (region_start_q[31]) begin
			init_first = ({1'b0, region_start_q[30:0]} + PG_MASK) >> PG_SH;
		end else begin
			init_first = '0;
		end
		init_load_val = (init_first >= NPU32) ? NPU_IDX : IDX_W'(init_first);

		push     = cmd.init_step || (cmd.free_exec && free_ok);
		push_idx = cmd.init_step ? cnt_q : free_idx;

		sts.init_more = (cnt_q < NPU_IDX);
		sts.head_null = (head_q == NULL_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= BASE_ADDR;
			head_q         <= NULL_IDX;
		end else begin
			if (cfg_write) begin
				region_start_q <= cfg_data;
			end
			if (push) begin
				head_q <= push_idx;
			end else if (cmd.alloc_wb) begin
				head_q <= rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			link_mem[push_idx[AW-1:0]] <= head_q;
		end
		if (cmd.alloc_rd) begin
			rd_q <= link_mem[head_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q   <= address;
			page_q   <= '0;
			status_q <= ST_DONE;
		end
		if (cmd.init_load) begin
			cnt_q <= init_load_val;
		end else if (cmd.init_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.free_exec && !free_ok) begin
			status_q <= ST_REJECT;
		end
		if (cmd.alloc_rd) begin
			if (sts.head_null) begin
				status_q <= ST_EMPTY;
			end else begin
				page_q <= BASE_ADDR + (32'(head_q[AW-1:0]) << PG_SH);
			end
		end
	end

	assign page_address = page_q;
	assign status       = status_q;

endmodule
`default_nettype wire

FILE: rtl/page_frame_free_list_allocator_core.sv
// Page frame allocator, LIFO free list of PAGE_BYTES pages above 0x8000_0000.
// Request channel: kind/address are taken at a rising edge with start high
// and busy low. kind 0 pushes every page from region_start (rounded up) to
// the top, kind 1 frees one page (status 1 if unaligned or out of range),
// kind 2 pops the newest page (status 2 and address 0 if the list is empty).
// Result channel: page_address/status are valid for the single cycle in
// which done is high; the receiver cannot stall it.
// Config: region_start is written whenever cfg_write is high; the user must
// write it only while idle, which the block does not enforce. Alloc reads the
// link memory, then writes the head back unless the list is empty; init loads
// a counter, then pushes pages. A new request is taken in the cycle done is
// high. The link memory has one port, used once per push and once per pop;
// init pushes one page per cycle through it.
// Reset empties the list and sets region_start to 0x8000_0000; link memory
// contents are not cleared, since every entry is written before it is read.
`default_nettype none
module page_frame_free_list_allocator_core
	import pffla_pkg::*;
#(
	parameter int NUM_PAGES  = 131072,
	parameter int PAGE_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] address,
	input  wire logic        cfg_write,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic [31:0]      page_address,
	output logic [1:0]       status
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	pffla_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pffla_dp #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.address      (address),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.page_address (page_address),
		.status       (status)
	);

endmodule
`default_nettype wire

FILE: rtl/pffla_chk.sv
`default_nettype none
module pffla_chk
	import pffla_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] page_address,
	input wire logic [1:0]  status
);

	// result cycle always frees the request side
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy high while result shown");

	// every finished operation ends in a result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("operation ended without result");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_REJECT || status == ST_EMPTY) |-> page_address == '0)
		else $error("failed request returned a page");

	a_page_base: assert property (@(posedge clk) disable iff (!arst_n)
		done && page_address != '0 |-> status == ST_DONE && page_address[31])
		else $error("returned page outside the region");

endmodule

bind page_frame_free_list_allocator_core pffla_chk u_chk (.*);
`default_nettype wire
